[hw/rtl/siph_pkg.sv]
// Shared types, constants and the SipRound function for the SipHash-2-4 hasher.
`timescale 1ns / 1ps

package siph_pkg;

	localparam int WORD_W    = 64;
	localparam int VB_W      = 4;
	localparam int CNT_W     = 8;
	localparam int CFG_IDX_W = 2;
	localparam int QDEPTH    = 2;
	localparam int QIDX_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;

	localparam logic [WORD_W-1:0] SIP_C0 = 64'h736f6d6570736575;
	localparam logic [WORD_W-1:0] SIP_C1 = 64'h646f72616e646f6d;
	localparam logic [WORD_W-1:0] SIP_C2 = 64'h6c7967656e657261;
	localparam logic [WORD_W-1:0] SIP_C3 = 64'h7465646279746573;
	localparam logic [WORD_W-1:0] KEY_LOW_RST  = 64'h0706050403020100;
	localparam logic [WORD_W-1:0] KEY_HIGH_RST = 64'h0f0e0d0c0b0a0908;
	localparam logic [WORD_W-1:0] FIN_XOR      = 64'h00000000000000ff;
	localparam logic [VB_W-1:0]   FULL_BYTES   = 4'd8;

	typedef logic [3:0][WORD_W-1:0] lanes_t;

	// Configuration write as seen by the front and back parts
	typedef struct packed {
		logic                 en;
		logic [CFG_IDX_W-1:0] index;
		logic [WORD_W-1:0]    data;
	} cfg_wr_t;

	// Work item handed from the front part to the back part
	typedef struct packed {
		logic [WORD_W-1:0] blk0;     // first block to compress
		logic [WORD_W-1:0] blk1;     // length-only block after a full last word
		logic              last;     // block ends the message
		logic              len_blk;  // blk1 must follow blk0
		logic [WORD_W-1:0] chain;
	} siph_cmd_t;

	function automatic lanes_t lanes_init(input logic [WORD_W-1:0] k0,
			input logic [WORD_W-1:0] k1);
		lanes_t v;
		v[0] = k0 ^ SIP_C0;
		v[1] = k1 ^ SIP_C1;
		v[2] = k0 ^ SIP_C2;
		v[3] = k1 ^ SIP_C3;
		return v;
	endfunction

	function automatic lanes_t sip_round(input lanes_t v);
		logic [WORD_W-1:0] a, b, c, d;
		a = v[0];
		b = v[1];
		c = v[2];
		d = v[3];
		a = a + b; b = {b[50:0], b[63:51]}; b = b ^ a; a = {a[31:0], a[63:32]};
		c = c + d; d = {d[47:0], d[63:48]}; d = d ^ c;
		a = a + d; d = {d[42:0], d[63:43]}; d = d ^ a;
		c = c + b; b = {b[46:0], b[63:47]}; b = b ^ c; c = {c[31:0], c[63:32]};
		return {d, c, b, a};
	endfunction

endpackage

[hw/rtl/siph_in_if.sv]
// Message word channel: valid/ready handshake with the word payload.
`timescale 1ns / 1ps

interface siph_in_if;
	import siph_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] message_word;
	logic [VB_W-1:0]   valid_bytes;
	logic              last_word;
	logic [WORD_W-1:0] chain_in;

	modport source(output valid, message_word, valid_bytes, last_word, chain_in,
		input ready);
	modport sink(input valid, message_word, valid_bytes, last_word, chain_in,
		output ready);
endinterface

[hw/rtl/siph_out_if.sv]
// Digest channel: valid/ready handshake with the hash payload.
`timescale 1ns / 1ps

interface siph_out_if;
	import siph_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] hash_out;

	modport source(output valid, hash_out, input ready);
	modport sink(input valid, hash_out, output ready);
endinterface

[hw/rtl/siph_front.sv]
// Front part: accepts message words, tracks the length and builds the blocks.
`timescale 1ns / 1ps

module siph_front
	import siph_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	siph_in_if.sink    msg,
	input  cfg_wr_t    cfg,
	input  logic       q_full,
	output logic       push,
	output siph_cmd_t  push_cmd
);

	logic [CNT_W-1:0]  byte_cnt_q;
	logic [VB_W-1:0]   nb;
	logic [VB_W-1:0]   add_bytes;
	logic [CNT_W-1:0]  cnt_sum;
	logic              is_full;
	logic [WORD_W-1:0] byte_mask;
	logic [WORD_W-1:0] len_blk;

	assign msg.ready = ~q_full;
	assign push      = msg.valid & ~q_full;

	// Clamp the byte count and form the length-tagged final block
	always_comb begin
		nb        = msg.valid_bytes[3] ? FULL_BYTES : msg.valid_bytes;
		is_full   = ~msg.last_word | (nb == FULL_BYTES);
		add_bytes = msg.last_word ? nb : FULL_BYTES;
		cnt_sum   = byte_cnt_q + CNT_W'(add_bytes);
		for (int i = 0; i < 8; i++) begin
			byte_mask[8*i +: 8] = (VB_W'(i) < nb) ? 8'hff : 8'h00;
		end
		len_blk = {cnt_sum, 56'd0};
		if (!is_full) begin
			len_blk = len_blk | (msg.message_word & byte_mask);
		end
	end

	// Classify the word into one or two blocks for the back part
	always_comb begin
		push_cmd.last    = msg.last_word;
		push_cmd.len_blk = msg.last_word & is_full;
		push_cmd.blk0    = is_full ? msg.message_word : len_blk;
		push_cmd.blk1    = len_blk;
		push_cmd.chain   = msg.chain_in;
	end

	// Advance the length count; drop it at message end or on a key write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
		end else if (cfg.en && (cfg.index == REG_KEY_LOW || cfg.index == REG_KEY_HIGH)) begin
			byte_cnt_q <= '0;
		end else if (push) begin
			byte_cnt_q <= msg.last_word ? '0 : cnt_sum;
		end
	end

endmodule

[hw/rtl/siph_queue.sv]
// Short command queue between the front and back parts.
`timescale 1ns / 1ps

module siph_queue
	import siph_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  siph_cmd_t push_cmd,
	input  logic      pop,
	output logic      full,
	output logic      empty,
	output siph_cmd_t head
);

	siph_cmd_t          mem_q [QDEPTH];
	logic [QIDX_W-1:0]  wr_ptr_q;
	logic [QIDX_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Store the pushed command
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QIDX_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QIDX_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/siph_back.sv]
// Back part: SipRound engine, finalization and the output register.
`timescale 1ns / 1ps

module siph_back
	import siph_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_wr_t    cfg,
	input  logic       q_empty,
	input  siph_cmd_t  head,
	output logic       pop,
	siph_out_if.source dgst
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CA   = 5'b00010,
		ST_CB   = 5'b00100,
		ST_FIN  = 5'b01000,
		ST_OUT  = 5'b10000
	} st_t;

	st_t               st_q;
	lanes_t            lanes_q;
	lanes_t            rnd_in;
	lanes_t            rnd_out;
	logic [WORD_W-1:0] key_low_q;
	logic [WORD_W-1:0] key_high_q;
	logic [WORD_W-1:0] m_q;
	logic [WORD_W-1:0] blk1_q;
	logic [WORD_W-1:0] chain_q;
	logic              last_q;
	logic              len_blk_q;
	logic [1:0]        fin_cnt_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] hash_q;
	logic              out_free;
	logic              emit;
	logic              key_wr;
	logic [WORD_W-1:0] new_k0;
	logic [WORD_W-1:0] new_k1;

	assign out_free   = ~out_valid_q | dgst.ready;
	assign pop        = (st_q == ST_IDLE) & ~q_empty;
	assign emit       = (st_q == ST_OUT) & out_free;
	assign dgst.valid    = out_valid_q;
	assign dgst.hash_out = hash_q;

	assign key_wr = cfg.en & (cfg.index == REG_KEY_LOW || cfg.index == REG_KEY_HIGH);
	assign new_k0 = (cfg.index == REG_KEY_LOW) ? cfg.data : key_low_q;
	assign new_k1 = (cfg.index == REG_KEY_HIGH) ? cfg.data : key_high_q;

	// Select the round input: message injection into v3, or 0xff into v2
	always_comb begin
		rnd_in = lanes_q;
		unique case (st_q)
			ST_IDLE: rnd_in[3] = lanes_q[3] ^ head.blk0;
			ST_CA:   rnd_in[3] = lanes_q[3] ^ m_q;
			ST_FIN:  if (fin_cnt_q == 2'd0) begin
					rnd_in[2] = lanes_q[2] ^ FIN_XOR;
				end
			default: rnd_in = lanes_q;
		endcase
		rnd_out = sip_round(rnd_in);
	end

	// Sequence the compressions and final rounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			lanes_q    <= lanes_init(KEY_LOW_RST, KEY_HIGH_RST);
			key_low_q  <= KEY_LOW_RST;
			key_high_q <= KEY_HIGH_RST;
			fin_cnt_q  <= '0;
		end else if (key_wr) begin
			key_low_q  <= new_k0;
			key_high_q <= new_k1;
			lanes_q    <= lanes_init(new_k0, new_k1);
			st_q       <= ST_IDLE;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (!q_empty) begin
						lanes_q <= rnd_out;
						st_q    <= ST_CB;
					end
				end
				ST_CA: begin
					lanes_q <= rnd_out;
					st_q    <= ST_CB;
				end
				ST_CB: begin
					lanes_q <= {rnd_out[3], rnd_out[2], rnd_out[1], rnd_out[0] ^ m_q};
					if (!last_q) begin
						st_q <= ST_IDLE;
					end else if (len_blk_q) begin
						st_q <= ST_CA;
					end else begin
						fin_cnt_q <= '0;
						st_q      <= ST_FIN;
					end
				end
				ST_FIN: begin
					lanes_q   <= rnd_out;
					fin_cnt_q <= fin_cnt_q + 1'b1;
					if (fin_cnt_q == 2'd3) begin
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						lanes_q <= lanes_init(key_low_q, key_high_q);
						st_q    <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the current command's payload
	always_ff @(posedge clk) begin
		if (pop) begin
			m_q       <= head.blk0;
			blk1_q    <= head.blk1;
			chain_q   <= head.chain;
			last_q    <= head.last;
			len_blk_q <= head.len_blk;
		end else if (st_q == ST_CB && last_q && len_blk_q) begin
			m_q       <= blk1_q;
			len_blk_q <= 1'b0;
		end
	end

	// Output register: load the digest, clear after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (dgst.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			hash_q <= lanes_q[0] ^ lanes_q[1] ^ lanes_q[2] ^ lanes_q[3] ^ chain_q;
		end
	end

endmodule

[hw/rtl/siphash24_stream_hasher.sv]
// Keyed SipHash-2-4 stream hasher: 64-bit message words in, one digest per message.
// A word that is not the last gets its compression rounds in the round engine (one SipRound a cycle).
// A partial last word also runs the finalization rounds on its way to the output register;
// a full last word first compresses the length block as well.
// A two-entry command queue lets words be taken while the round engine is busy.
// Reset (arst_n low) loads the default key, clears the length count and drops pending work.
`timescale 1ns / 1ps

module siphash24_stream_hasher
	import siph_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	siph_in_if.sink              msg,
	siph_out_if.source           dgst,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [WORD_W-1:0]    wr_data
);

	cfg_wr_t   cfg;
	siph_cmd_t push_cmd;
	siph_cmd_t head;
	logic      push;
	logic      pop;
	logic      q_full;
	logic      q_empty;

	assign cfg.en    = wr_en;
	assign cfg.index = wr_index;
	assign cfg.data  = wr_data;

	siph_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.msg      (msg),
		.cfg      (cfg),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	siph_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	siph_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_empty (q_empty),
		.head    (head),
		.pop     (pop),
		.dgst    (dgst)
	);

endmodule

[hw/rtl/siph_checker.sv]
// Port-level checks for the SipHash-2-4 stream hasher, bound to the top level.
`timescale 1ns / 1ps

module siph_checker
	import siph_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              in_last,
	input logic              out_valid,
	input logic              out_ready,
	input logic [WORD_W-1:0] hash_out
);

	logic [2:0] pend_q;
	logic       last_xfer;
	logic       out_xfer;

	assign last_xfer = in_valid & in_ready & in_last;
	assign out_xfer  = out_valid & out_ready;

	// Track messages whose digest is still owed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (last_xfer && !out_xfer) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_xfer && !last_xfer) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hash_out))
		else $error("digest changed or dropped while stalled");

	a_no_extra_digest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0)
		else $error("digest offered with no message outstanding");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("digest valid during reset");

	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		last_xfer && pend_q == 3'd0 |=> !out_valid)
		else $error("digest appeared one cycle after its last word");

endmodule

bind siphash24_stream_hasher siph_checker u_siph_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (msg.valid),
	.in_ready  (msg.ready),
	.in_last   (msg.last_word),
	.out_valid (dgst.valid),
	.out_ready (dgst.ready),
	.hash_out  (dgst.hash_out)
);
